// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the tokenizer RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must hold in the same cycle whenever the condition is true.
`define ASSERT_IMPLIES(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`endif

// ===== rtl/core/qatt_pkg.sv =====
// Shared types, character constants and classification functions for the
// quote-aware text tokenizer. No dependencies.
package qatt_pkg;

    localparam logic [7:0] CH_DQ     = 8'h22;
    localparam logic [7:0] CH_SQ     = 8'h27;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic [1:0] CLS_WS     = 2'd0;
    localparam logic [1:0] CLS_ID     = 2'd1;
    localparam logic [1:0] CLS_OTHER  = 2'd2;
    localparam logic [1:0] CLS_STRING = 2'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [1:0] {
        QK_NONE,
        QK_DOUBLE,
        QK_SINGLE
    } quote_kind_t;

    typedef enum logic [1:0] {
        RUN_NONE,
        RUN_WS,
        RUN_ID
    } run_kind_t;

    // One classified input byte as it travels from the front to the back.
    typedef struct packed {
        logic [7:0]  data;
        logic        eof;
        logic        esc;
        quote_kind_t quote;
        logic        abort;
    } front_item_t;

    typedef struct packed {
        logic       start;
        logic [1:0] cls;
        run_kind_t  run;
    } tag_t;

    function automatic logic is_ws(input logic [7:0] b);
        return b inside {[CH_TAB:CH_CR], CH_SPACE};
    endfunction

    function automatic logic is_id_first(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_DOLLAR, CH_USCORE};
    endfunction

    function automatic logic is_id_more(input logic [7:0] b);
        return is_id_first(b) || b == CH_DOT || b == CH_SLASH;
    endfunction

    // Tag for a byte emitted outside a string, given the run that is open.
    function automatic tag_t plain_tag(input logic [7:0] b, input run_kind_t run);
        tag_t t;
        if (run == RUN_WS && is_ws(b))
        begin
            t.start = 1'b0;
            t.cls   = CLS_WS;
            t.run   = RUN_WS;
        end
        else if (run == RUN_ID && is_id_more(b))
        begin
            t.start = 1'b0;
            t.cls   = CLS_ID;
            t.run   = RUN_ID;
        end
        else if (is_ws(b))
        begin
            t.start = 1'b1;
            t.cls   = CLS_WS;
            t.run   = RUN_WS;
        end
        else if (is_id_first(b))
        begin
            t.start = 1'b1;
            t.cls   = CLS_ID;
            t.run   = RUN_ID;
        end
        else
        begin
            t.start = 1'b1;
            t.cls   = CLS_OTHER;
            t.run   = RUN_NONE;
        end
        return t;
    endfunction

endpackage

// ===== rtl/core/qatt_front.sv =====
// Input side of the tokenizer: accepts bytes and classifies them.
// Depends on qatt_pkg.
module qatt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] in_byte
    input  logic                s_tlast,   // end_of_file
    input  logic                fifo_full,
    output logic                push,
    output qatt_pkg::front_item_t push_item
);
    import qatt_pkg::*;

    logic [7:0] prev_reg;
    logic [7:0] prev_next;

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        push_item.data  = s_tdata;
        push_item.eof   = s_tlast;
        push_item.esc   = (prev_reg == CH_BSL);
        push_item.abort = (s_tdata < CH_SPACE) || (s_tdata >= CH_DEL);
        if (s_tdata == CH_DQ)
        begin
            push_item.quote = QK_DOUBLE;
        end
        else if (s_tdata == CH_SQ)
        begin
            push_item.quote = QK_SINGLE;
        end
        else
        begin
            push_item.quote = QK_NONE;
        end
    end

    // End of file forgets the previous byte, so the next text starts clean.
    always_comb
    begin
        prev_next = prev_reg;
        if (push)
        begin
            prev_next = s_tlast ? 8'h00 : s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 8'h00;
        end
        else
        begin
            prev_reg <= prev_next;
        end
    end

endmodule

// ===== rtl/core/qatt_fifo.sv =====
// Short queue of classified bytes between the front and the back.
// Depends on qatt_pkg.
module qatt_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  qatt_pkg::front_item_t push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output qatt_pkg::front_item_t head
);
    import qatt_pkg::*;

    front_item_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/qatt_back.sv =====
// Output side of the tokenizer: string state, hold buffer and token tagging.
// Depends on qatt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qatt_back #(
    parameter int HOLD_DEPTH = 63
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  qatt_pkg::front_item_t head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tlast,   // last_result
    output logic [3:0]            m_tuser    // [0] token_start, [2:1] token_class,
                                             // [3] forced_release
);
    import qatt_pkg::*;

    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = $clog2(HOLD_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_TAIL
    } state_t;

    // What happens to the byte itself once the held bytes are out.
    typedef enum logic [1:0] {
        T_NONE,
        T_STRING,
        T_PLAIN,
        T_HOLD
    } tail_t;

    state_t       state_reg, state_next;
    quote_kind_t  open_reg, open_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    run_kind_t    run_reg, run_next;
    logic [7:0]   byte_reg, byte_next;
    logic         eof_reg, eof_next;
    logic [CNT_W-1:0] drain_reg, drain_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic         string_reg, string_next;
    logic         forced_reg, forced_next;
    tail_t        tail_reg, tail_next;
    logic         m_tvalid_reg, m_tvalid_next;
    logic [7:0]   m_tdata_reg, m_tdata_next;
    logic         m_tlast_reg, m_tlast_next;
    logic [3:0]   m_tuser_reg, m_tuser_next;

    logic [7:0]   held_mem [HOLD_DEPTH];
    logic [7:0]   rd_data_reg;
    logic         mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [7:0]   mem_wd;

    logic         load_ok;
    logic         full;
    logic         closes;
    logic         opens;
    logic         drain_last;
    logic         out_last;
    tag_t         drain_tag;
    tag_t         tail_tag;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    assign load_ok    = !m_tvalid_reg || m_tready;
    assign full       = (cnt_reg >= CNT_W'(HOLD_DEPTH));
    assign closes     = (open_reg != QK_NONE) && !head.esc && (head.quote == open_reg);
    assign opens      = (head.quote != QK_NONE) && !head.esc && !head.eof;
    assign drain_last = (CNT_W'(idx_reg) == drain_reg - CNT_W'(1));

    always_comb
    begin
        if (string_reg)
        begin
            drain_tag.start = (idx_reg == '0);
            drain_tag.cls   = CLS_STRING;
            drain_tag.run   = run_reg;
        end
        else
        begin
            drain_tag = plain_tag(rd_data_reg, run_reg);
        end
        if (tail_reg == T_STRING)
        begin
            tail_tag.start = (drain_reg == '0);
            tail_tag.cls   = CLS_STRING;
            tail_tag.run   = RUN_NONE;
        end
        else
        begin
            tail_tag = plain_tag(byte_reg, run_reg);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        open_next     = open_reg;
        cnt_next      = cnt_reg;
        run_next      = run_reg;
        byte_next     = byte_reg;
        eof_next      = eof_reg;
        drain_next    = drain_reg;
        idx_next      = idx_reg;
        string_next   = string_reg;
        forced_next   = forced_reg;
        tail_next     = tail_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        pop           = 1'b0;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = head.data;
        out_last      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop         = 1'b1;
                    byte_next   = head.data;
                    eof_next    = head.eof;
                    drain_next  = '0;
                    idx_next    = '0;
                    string_next = 1'b0;
                    forced_next = 1'b0;
                    tail_next   = T_NONE;
                    if (open_reg != QK_NONE)
                    begin
                        if (closes)
                        begin
                            drain_next  = cnt_reg;
                            string_next = 1'b1;
                            tail_next   = T_STRING;
                            open_next   = QK_NONE;
                            cnt_next    = '0;
                        end
                        else if (head.abort)
                        begin
                            drain_next = cnt_reg;
                            tail_next  = T_PLAIN;
                            open_next  = QK_NONE;
                            cnt_next   = '0;
                        end
                        else if (full)
                        begin
                            // The byte that found the buffer full may open a new string;
                            // it is written to entry zero after the old bytes are out.
                            drain_next  = cnt_reg;
                            forced_next = 1'b1;
                            if (opens)
                            begin
                                tail_next = T_HOLD;
                                open_next = head.quote;
                                cnt_next  = CNT_W'(1);
                            end
                            else
                            begin
                                tail_next = T_PLAIN;
                                open_next = QK_NONE;
                                cnt_next  = '0;
                            end
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            mem_wa = cnt_reg[IDX_W-1:0];
                            if (head.eof)
                            begin
                                drain_next = cnt_reg + CNT_W'(1);
                                open_next  = QK_NONE;
                                cnt_next   = '0;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                    end
                    else if (opens)
                    begin
                        mem_we    = 1'b1;
                        mem_wa    = '0;
                        open_next = head.quote;
                        cnt_next  = CNT_W'(1);
                    end
                    else
                    begin
                        tail_next = T_PLAIN;
                    end

                    if (drain_next != '0)
                    begin
                        state_next = S_RD;
                    end
                    else if (tail_next != T_NONE)
                    begin
                        state_next = S_TAIL;
                    end
                end
            end

            S_RD:
            begin
                state_next = S_WR;
            end

            S_WR:
            begin
                if (load_ok)
                begin
                    out_last      = drain_last && (tail_reg == T_NONE || tail_reg == T_HOLD);
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rd_data_reg;
                    m_tlast_next  = out_last;
                    m_tuser_next  = {forced_reg, drain_tag.cls, drain_tag.start};
                    run_next      = (out_last && eof_reg) ? RUN_NONE : drain_tag.run;
                    if (drain_last)
                    begin
                        state_next = (tail_reg != T_NONE) ? S_TAIL : S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_RD;
                    end
                end
            end

            S_TAIL:
            begin
                if (tail_reg == T_HOLD)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = '0;
                    mem_wd     = byte_reg;
                    state_next = S_IDLE;
                end
                else if (load_ok)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = byte_reg;
                    m_tlast_next  = 1'b1;
                    m_tuser_next  = {forced_reg, tail_tag.cls, tail_tag.start};
                    run_next      = eof_reg ? RUN_NONE : tail_tag.run;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            open_reg     <= QK_NONE;
            cnt_reg      <= '0;
            run_reg      <= RUN_NONE;
            byte_reg     <= 8'h00;
            eof_reg      <= 1'b0;
            drain_reg    <= '0;
            idx_reg      <= '0;
            string_reg   <= 1'b0;
            forced_reg   <= 1'b0;
            tail_reg     <= T_NONE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= 8'h00;
            m_tlast_reg  <= 1'b0;
            m_tuser_reg  <= 4'h0;
        end
        else
        begin
            state_reg    <= state_next;
            open_reg     <= open_next;
            cnt_reg      <= cnt_next;
            run_reg      <= run_next;
            byte_reg     <= byte_next;
            eof_reg      <= eof_next;
            drain_reg    <= drain_next;
            idx_reg      <= idx_next;
            string_reg   <= string_next;
            forced_reg   <= forced_next;
            tail_reg     <= tail_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tlast_reg  <= m_tlast_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    // Hold buffer: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            held_mem[mem_wa] <= mem_wd;
        end
        if (state_reg == S_RD)
        begin
            rd_data_reg <= held_mem[idx_reg];
        end
    end

    `ASSERT_CLK(a_cnt_bound, cnt_reg <= CNT_W'(HOLD_DEPTH), "held count above hold depth")
    `ASSERT_CLK(a_open_cnt, (open_reg == QK_NONE) == (cnt_reg == '0), "open quote and held count disagree")
    `ASSERT_IMPLIES(a_idx_range, state_reg == S_RD || state_reg == S_WR, CNT_W'(idx_reg) < drain_reg, "drain index past drain length")

endmodule

// ===== rtl/core/quote_aware_text_tokenizer.sv =====
// A byte emitted at once passes a queue entry, the back-end byte register and output register.
// The input takes a beat per cycle while the four-entry queue has room. The back end takes a
// byte it emits at once through its idle and tail states, a byte it holds through its idle
// state, and each held byte it drains through a memory read and an output load.
// Reset clears the queue, string state, held count and output register; the hold memory is
// not cleared, as only entries written since the string opened are ever read.
module quote_aware_text_tokenizer #(
    parameter int HOLD_DEPTH = 63
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_file
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // last_result
    output logic [3:0] m_tuser    // [0] token_start, [2:1] token_class, [3] forced_release
);
    import qatt_pkg::*;

    logic        push;
    front_item_t push_item;
    logic        fifo_full;
    logic        pop;
    logic        head_valid;
    front_item_t head;

    qatt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    qatt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    qatt_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== bench/tb_quote_aware_text_tokenizer.sv =====
// Self-checking testbench for the quote-aware text tokenizer: directed rows, then random text.
// Depends on qatt_pkg for character, class and state codes; predicts the beats of untyped rows itself.
module tb_quote_aware_text_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import qatt_pkg::*;

    localparam int HOLD_DEPTH   = 63;
    localparam int TEXT_ITEMS   = 220;
    localparam int DRAIN_CYCLES = 40;

    // Gap styles for either side of the block.
    localparam int GAP_NONE  = 0;
    localparam int GAP_LIGHT = 1;
    localparam int GAP_HEAVY = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       typed;   // expected beat is written in the row
        logic       start;
        logic [1:0] cls;
    } text_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic [1:0] cls;
        logic       forced;
        logic       is_last;
    } token_beat_t;

    // Typed rows give exactly one beat with forced_release low and last_result high.
    localparam text_row_t DIRECTED [24] = '{
        '{8'h61, 1'b0, 1'b1, 1'b1, CLS_ID},
        '{8'h62, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h2E, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h20, 1'b0, 1'b1, 1'b1, CLS_WS},
        '{8'h09, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h0D, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h00, 1'b0, 1'b1, 1'b1, CLS_OTHER},
        '{8'hFF, 1'b0, 1'b1, 1'b1, CLS_OTHER},
        '{8'h5C, 1'b0, 1'b1, 1'b1, CLS_OTHER},
        '{8'h22, 1'b0, 1'b1, 1'b1, CLS_OTHER},
        '{8'h22, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h78, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h27, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h5C, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h22, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h22, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h71, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h27, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h7A, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h0A, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h22, 1'b0, 1'b0, 1'b0, CLS_WS},
        '{8'h6B, 1'b1, 1'b0, 1'b0, CLS_WS},
        '{8'h7F, 1'b0, 1'b1, 1'b1, CLS_OTHER},
        '{8'h24, 1'b1, 1'b1, 1'b1, CLS_ID}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [3:0] m_tuser;

    quote_aware_text_tokenizer #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    text_row_t   text_rows[$];
    token_beat_t expected_tokens[$];
    token_beat_t step_beats[$];
    int          error_count = 0;
    logic [7:0]  last_added = 8'h00;

    // Tokenizer state as the predictor sees it.
    logic [7:0]  hold_mem [HOLD_DEPTH];
    int          hold_cnt;
    quote_kind_t open_quote;
    logic [7:0]  prev_b;
    run_kind_t   run;

    task automatic note_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic logic tok_space(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic tok_id_head(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A) || b == CH_DOLLAR || b == CH_USCORE;
    endfunction

    function automatic logic tok_id_tail(input logic [7:0] b);
        return tok_id_head(b) || b == CH_DOT || b == CH_SLASH;
    endfunction

    function void emit_beat(input logic [7:0] b, input logic start, input logic [1:0] cls,
                            input logic forced);
        token_beat_t t;
        t.data    = b;
        t.start   = start;
        t.cls     = cls;
        t.forced  = forced;
        t.is_last = 1'b0;
        step_beats = {step_beats, t};
    endfunction

    function void emit_plain(input logic [7:0] b, input logic forced);
        if (run == RUN_WS && tok_space(b))
            emit_beat(b, 1'b0, CLS_WS, forced);
        else if (run == RUN_ID && tok_id_tail(b))
            emit_beat(b, 1'b0, CLS_ID, forced);
        else if (tok_space(b))
        begin
            run = RUN_WS;
            emit_beat(b, 1'b1, CLS_WS, forced);
        end
        else if (tok_id_head(b))
        begin
            run = RUN_ID;
            emit_beat(b, 1'b1, CLS_ID, forced);
        end
        else
        begin
            run = RUN_NONE;
            emit_beat(b, 1'b1, CLS_OTHER, forced);
        end
    endfunction

    function void release_held(input logic forced);
        for (int i = 0; i < hold_cnt; i++)
            emit_plain(hold_mem[i], forced);
        hold_cnt   = 0;
        open_quote = QK_NONE;
    endfunction

    function void take_outside(input logic [7:0] b, input logic forced);
        if ((b == CH_DQ || b == CH_SQ) && prev_b != CH_BSL)
        begin
            open_quote  = (b == CH_DQ) ? QK_DOUBLE : QK_SINGLE;
            hold_mem[0] = b;
            hold_cnt    = 1;
        end
        else
            emit_plain(b, forced);
    endfunction

    function void clear_tokenizer();
        hold_cnt   = 0;
        open_quote = QK_NONE;
        prev_b     = 8'h00;
        run        = RUN_NONE;
    endfunction

    // Leaves the beats caused by one accepted text byte in step_beats.
    function void tokenize_byte(input logic [7:0] b, input logic eof);
        logic closes;
        logic forced;
        step_beats.delete();
        if (open_quote != QK_NONE)
        begin
            closes = prev_b != CH_BSL &&
                     ((b == CH_DQ && open_quote == QK_DOUBLE) ||
                      (b == CH_SQ && open_quote == QK_SINGLE));
            if (closes)
            begin
                for (int i = 0; i < hold_cnt; i++)
                    emit_beat(hold_mem[i], i == 0, CLS_STRING, 1'b0);
                emit_beat(b, step_beats.size() == 0, CLS_STRING, 1'b0);
                hold_cnt   = 0;
                open_quote = QK_NONE;
                run        = RUN_NONE;
            end
            else if (b < CH_SPACE || b >= CH_DEL)
            begin
                release_held(1'b0);
                take_outside(b, 1'b0);
            end
            else if (hold_cnt >= HOLD_DEPTH)
            begin
                release_held(1'b1);
                take_outside(b, 1'b1);
            end
            else
            begin
                hold_mem[hold_cnt] = b;
                hold_cnt++;
            end
        end
        else
            take_outside(b, 1'b0);
        prev_b = b;
        if (eof)
        begin
            // A string still open at end of file keeps the flag of this step's first beat.
            if (open_quote != QK_NONE)
            begin
                forced = (step_beats.size() > 0) ? step_beats[0].forced : 1'b0;
                release_held(forced);
            end
            clear_tokenizer();
        end
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].is_last = 1'b1;
    endfunction

    function automatic int draw_gap(input int style);
        case (style)
            GAP_NONE:  return 0;
            GAP_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
            default:   return $urandom_range(0, 17);
        endcase
    endfunction

    function void add_byte(input logic [7:0] b, input logic eof);
        text_row_t r;
        r.data  = b;
        r.eof   = eof;
        r.typed = 1'b0;
        r.start = 1'b0;
        r.cls   = CLS_WS;
        text_rows = {text_rows, r};
        last_added = b;
    endfunction

    function automatic logic [7:0] pick_char(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // Printable byte that is neither a quote nor a backslash.
    function automatic logic [7:0] plain_printable();
        logic [7:0] b;
        do
            b = 8'($urandom_range(8'h20, 8'h7E));
        while (b == CH_DQ || b == CH_SQ || b == CH_BSL);
        return b;
    endfunction

    function automatic logic [7:0] quote_of(input logic dq);
        return dq ? CH_DQ : CH_SQ;
    endfunction

    // String content: the other quote kind and escaped quotes mixed into printable bytes.
    function void add_string_body(input logic dq, input int pieces);
        int r;
        for (int i = 0; i < pieces; i++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                add_byte(quote_of(!dq), 1'b0);
            else if (r == 1)
            begin
                add_byte(CH_BSL, 1'b0);
                add_byte(quote_of(dq), 1'b0);
            end
            else
                add_byte(plain_printable(), 1'b0);
        end
    endfunction

    function void open_string(input logic dq);
        if (last_added == CH_BSL)
            add_byte(CH_SPACE, 1'b0);
        add_byte(quote_of(dq), 1'b0);
    endfunction

    function automatic logic [7:0] abort_byte();
        return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h00, 8'h1F))
                                           : 8'($urandom_range(8'h7F, 8'hFF));
    endfunction

    // Fills the hold buffer to the brim, then sends the byte that overflows or closes it.
    function void add_long_string();
        logic dq;
        int   r;
        dq = 1'($urandom_range(0, 1));
        open_string(dq);
        for (int i = 1; i < HOLD_DEPTH; i++)
            add_byte(plain_printable(), 1'b0);
        r = $urandom_range(0, 2);
        if (r == 0)
            add_byte(plain_printable(), $urandom_range(0, 3) == 0);
        else if (r == 1)
        begin
            add_byte(quote_of(!dq), $urandom_range(0, 2) == 0);
            if (!text_rows[text_rows.size() - 1].eof)
            begin
                add_string_body(!dq, $urandom_range(0, 3));
                add_byte(quote_of(!dq), 1'b0);
            end
        end
        else
            add_byte(quote_of(dq), 1'b0);
    endfunction

    function void build_random_text();
        int long_strings;
        int k;
        int n;
        logic dq;
        long_strings = 1;
        add_long_string();
        while (text_rows.size() < TEXT_ITEMS)
        begin
            k = $urandom_range(0, 15);
            if (k <= 2)
            begin
                add_byte(pick_char("abcxyzAMZ0159$_"), 1'b0);
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                    add_byte(pick_char("aqzBQZ0479$_./"), 1'b0);
            end
            else if (k <= 4)
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    add_byte(pick_char(" \t\n\v\f\r"), 1'b0);
            end
            else if (k == 5)
            begin
                if ($urandom_range(0, 2) == 0)
                    add_byte(abort_byte(), 1'b0);
                else
                    add_byte(pick_char("!#%&()*+,-:;<=>?@[]^{|}~\\"), 1'b0);
            end
            else if (k <= 9 || (k == 13 && long_strings >= 3))
            begin
                dq = 1'($urandom_range(0, 1));
                open_string(dq);
                add_string_body(dq, $urandom_range(0, 8));
                add_byte(quote_of(dq), 1'b0);
            end
            else if (k <= 11)
            begin
                dq = 1'($urandom_range(0, 1));
                open_string(dq);
                add_string_body(dq, $urandom_range(0, 6));
                add_byte(abort_byte(), 1'b0);
            end
            else if (k == 12)
            begin
                dq = 1'($urandom_range(0, 1));
                open_string(dq);
                add_string_body(dq, $urandom_range(0, 6));
                text_rows[text_rows.size() - 1].eof = 1'b1;
            end
            else if (k == 13)
            begin
                long_strings++;
                add_long_string();
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            if ($urandom_range(0, 11) == 0)
                text_rows[text_rows.size() - 1].eof = 1'b1;
        end
        // Close the text so that nothing stays held at the end.
        text_rows[text_rows.size() - 1].eof = 1'b1;
    endfunction

    // Output side: random stalls, each beat checked against the oldest expectation.
    initial
    begin : token_sink
        int gap;
        int style;
        int style_left;
        token_beat_t want;
        style      = GAP_NONE;
        style_left = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (style_left == 0)
            begin
                style      = $urandom_range(GAP_NONE, GAP_HEAVY);
                style_left = $urandom_range(20, 40);
            end
            style_left--;
            gap = draw_gap(style);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            if (expected_tokens.size() == 0)
                note_mismatch($sformatf("unexpected beat data=%02h tuser=%h last=%b",
                                        m_tdata, m_tuser, m_tlast));
            else
            begin
                want = expected_tokens.pop_front();
                if (m_tdata !== want.data)
                    note_mismatch($sformatf("out_byte %02h, expected %02h",
                                            m_tdata, want.data));
                if (m_tuser[0] !== want.start)
                    note_mismatch($sformatf("token_start %b, expected %b (byte %02h)",
                                            m_tuser[0], want.start, want.data));
                if (m_tuser[2:1] !== want.cls)
                    note_mismatch($sformatf("token_class %0d, expected %0d (byte %02h)",
                                            m_tuser[2:1], want.cls, want.data));
                if (m_tuser[3] !== want.forced)
                    note_mismatch($sformatf("forced_release %b, expected %b (byte %02h)",
                                            m_tuser[3], want.forced, want.data));
                if (m_tlast !== want.is_last)
                    note_mismatch($sformatf("last_result %b, expected %b (byte %02h)",
                                            m_tlast, want.is_last, want.data));
            end
        end
    end

    initial
    begin : text_source
        int gap;
        int style;
        int style_left;
        text_row_t row;
        token_beat_t t;
        style      = GAP_NONE;
        style_left = 0;
        clear_tokenizer();
        foreach (DIRECTED[i])
            text_rows = {text_rows, DIRECTED[i]};
        build_random_text();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (text_rows[i])
        begin
            row = text_rows[i];
            if (style_left == 0)
            begin
                style      = $urandom_range(GAP_NONE, GAP_HEAVY);
                style_left = $urandom_range(20, 40);
            end
            style_left--;
            gap = draw_gap(style);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= row.data;
            s_tlast  <= row.eof;
            do
                @(posedge clk);
            while (s_tready !== 1'b1);
            tokenize_byte(row.data, row.eof);
            if (row.typed)
            begin
                step_beats.delete();
                t.data    = row.data;
                t.start   = row.start;
                t.cls     = row.cls;
                t.forced  = 1'b0;
                t.is_last = 1'b1;
                step_beats = {step_beats, t};
            end
            foreach (step_beats[j])
                expected_tokens = {expected_tokens, step_beats[j]};
        end
        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(20_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/qatt_pkg.sv
rtl/core/qatt_front.sv
rtl/core/qatt_fifo.sv
rtl/core/qatt_back.sv
rtl/core/quote_aware_text_tokenizer.sv
bench/tb_quote_aware_text_tokenizer.sv
